/* rtl/neighbor_table_with_aging_top_assert.svh */
// assertion macros for the neighbor table blocks
`ifndef NEIGHBOR_TABLE_WITH_AGING_TOP_ASSERT_SVH
`define NEIGHBOR_TABLE_WITH_AGING_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define NTWA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// expression must never be true outside reset
`define NTWA_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define NTWA_ASSERT(lbl, clk, rst, prop, msg)
`define NTWA_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

/* rtl/ntwa_pkg.sv */
// types and constants shared by the neighbor table modules
`timescale 1ns / 1ps

package ntwa_pkg;

  localparam int MAC_W    = 48;
  localparam int TIME_W   = 32;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;
  localparam int ENTRY_W  = MAC_W + TIME_W;

  localparam logic [TIME_W-1:0] AGE_LIMIT_RESET = 32'd30000;

  // item modes
  localparam logic MODE_SEEN  = 1'b0;
  localparam logic MODE_PRUNE = 1'b1;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_OWN_ADDRESS = 1'b0,
    CFG_AGE_LIMIT   = 1'b1
  } cfg_reg_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_REFRESHED  = 3'd0,
    ST_LEARNED    = 3'd1,
    ST_SELF       = 3'd2,
    ST_FULL       = 3'd3,
    ST_REMOVED    = 3'd4,
    ST_PRUNE_DONE = 3'd5
  } status_t;

  // scan sequencer states
  typedef enum logic [1:0] {
    SC_IDLE,
    SC_SCAN,
    SC_DONE
  } scan_state_t;

  typedef struct packed {
    logic              mode;
    logic [MAC_W-1:0]  neighbor_mac;
    logic [TIME_W-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [MAC_W-1:0]   entry_mac;
    logic [COUNT_W-1:0] active_count;
    logic               last;
  } result_t;

  // configuration seen by the scanner
  typedef struct packed {
    logic [MAC_W-1:0]  own_address;
    logic [TIME_W-1:0] age_limit;
  } cfg_t;

endpackage

/* rtl/ntwa_ram.sv */
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module ntwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ntwa_scan.sv */
// scan sequencer: walks the table ram, keeps valid bits and the active count
`timescale 1ns / 1ps
`include "neighbor_table_with_aging_top_assert.svh"

module ntwa_scan
  import ntwa_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  in_item_t           item,
  input  cfg_t               cfg,
  output logic               ram_we,
  output logic [IW-1:0]      ram_waddr,
  output logic [ENTRY_W-1:0] ram_wdata,
  output logic [IW-1:0]      ram_raddr,
  input  logic [ENTRY_W-1:0] ram_rdata,
  output logic               done,
  output result_t            result
);

  scan_state_t       state, state_next;
  logic              cur_mode, cur_mode_next;
  logic [MAC_W-1:0]  cur_mac, cur_mac_next;
  logic [TIME_W-1:0] cur_now, cur_now_next;
  logic [CW-1:0]     rd_idx, rd_idx_next;
  logic              chk_vld, chk_vld_next;
  logic [IW-1:0]     chk_idx, chk_idx_next;
  logic              free_found, free_found_next;
  logic [IW-1:0]     free_idx, free_idx_next;
  logic [CW-1:0]     count, count_next;
  logic [TABLE_DEPTH-1:0] valid, valid_next;
  result_t           res_next;
  logic              done_next;

  logic              rd_issue;
  logic              slot_valid;
  logic [MAC_W-1:0]  rd_mac;
  logic [TIME_W-1:0] rd_time;
  logic [TIME_W-1:0] age;
  logic              hit;
  logic              stale;
  logic              last_slot;
  logic              fnd;
  logic [IW-1:0]     fidx;

  assign busy      = (state != SC_IDLE);
  assign rd_issue  = (state == SC_SCAN) && (rd_idx < CW'(TABLE_DEPTH));
  assign ram_raddr = rd_idx[IW-1:0];
  assign rd_mac    = ram_rdata[ENTRY_W-1:TIME_W];
  assign rd_time   = ram_rdata[TIME_W-1:0];
  assign age       = cur_now - rd_time;
  assign slot_valid = valid[chk_idx];
  assign hit       = chk_vld && slot_valid && (rd_mac == cur_mac);
  assign stale     = chk_vld && slot_valid && (age > cfg.age_limit);
  assign last_slot = (chk_idx == IW'(TABLE_DEPTH - 1));
  assign fnd       = free_found || !slot_valid;
  assign fidx      = free_found ? free_idx : chk_idx;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= SC_IDLE;
      rd_idx     <= '0;
      chk_vld    <= 1'b0;
      free_found <= 1'b0;
      count      <= '0;
      valid      <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      rd_idx     <= rd_idx_next;
      chk_vld    <= chk_vld_next;
      free_found <= free_found_next;
      count      <= count_next;
      valid      <= valid_next;
      done       <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_mode <= cur_mode_next;
    cur_mac  <= cur_mac_next;
    cur_now  <= cur_now_next;
    chk_idx  <= chk_idx_next;
    free_idx <= free_idx_next;
    result   <= res_next;
  end

  // next state, memory access and result
  always_comb begin
    state_next      = state;
    cur_mode_next   = cur_mode;
    cur_mac_next    = cur_mac;
    cur_now_next    = cur_now;
    rd_idx_next     = rd_idx;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    count_next      = count;
    valid_next      = valid;
    res_next        = result;
    done_next       = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = chk_idx;
    ram_wdata       = {cur_mac, cur_now};

    case (state)
      SC_IDLE: begin
        if (start) begin
          cur_mode_next = item.mode;
          cur_mac_next  = item.neighbor_mac;
          cur_now_next  = item.now_time;
          if (item.mode == MODE_SEEN && item.neighbor_mac == cfg.own_address) begin
            done_next             = 1'b1;
            res_next.status       = ST_SELF;
            res_next.slot         = '0;
            res_next.entry_mac    = item.neighbor_mac;
            res_next.active_count = COUNT_W'(count);
            res_next.last         = 1'b1;
          end else begin
            state_next      = SC_SCAN;
            rd_idx_next     = '0;
            free_found_next = 1'b0;
          end
        end
      end

      SC_SCAN: begin
        if (rd_issue) begin
          rd_idx_next = rd_idx + CW'(1);
        end
        if (chk_vld) begin
          if (cur_mode == MODE_SEEN) begin
            if (hit) begin
              // known neighbor: refresh its time
              ram_we                = 1'b1;
              ram_waddr             = chk_idx;
              done_next             = 1'b1;
              res_next.status       = ST_REFRESHED;
              res_next.slot         = SLOT_W'(chk_idx);
              res_next.entry_mac    = cur_mac;
              res_next.active_count = COUNT_W'(count);
              res_next.last         = 1'b1;
              state_next            = SC_IDLE;
            end else begin
              // remember the lowest free slot
              free_found_next = fnd;
              free_idx_next   = fidx;
              if (last_slot) begin
                done_next          = 1'b1;
                res_next.entry_mac = cur_mac;
                res_next.last      = 1'b1;
                state_next         = SC_IDLE;
                if (fnd) begin
                  ram_we                = 1'b1;
                  ram_waddr             = fidx;
                  valid_next[fidx]      = 1'b1;
                  count_next            = count + CW'(1);
                  res_next.status       = ST_LEARNED;
                  res_next.slot         = SLOT_W'(fidx);
                  res_next.active_count = COUNT_W'(count + CW'(1));
                end else begin
                  res_next.status       = ST_FULL;
                  res_next.slot         = '0;
                  res_next.active_count = COUNT_W'(count);
                end
              end
            end
          end else begin
            // prune: drop an entry older than the limit
            if (stale) begin
              valid_next[chk_idx]   = 1'b0;
              count_next            = count - CW'(1);
              done_next             = 1'b1;
              res_next.status       = ST_REMOVED;
              res_next.slot         = SLOT_W'(chk_idx);
              res_next.entry_mac    = rd_mac;
              res_next.active_count = COUNT_W'(count - CW'(1));
              res_next.last         = 1'b0;
            end
            if (last_slot) begin
              state_next = SC_DONE;
            end
          end
        end
      end

      SC_DONE: begin
        // closing summary of a prune run
        done_next             = 1'b1;
        res_next.status       = ST_PRUNE_DONE;
        res_next.slot         = '0;
        res_next.entry_mac    = '0;
        res_next.active_count = COUNT_W'(count);
        res_next.last         = 1'b1;
        state_next            = SC_IDLE;
      end

      default: begin
        state_next = SC_IDLE;
      end
    endcase
  end

  // read pipeline tag
  assign chk_vld_next = rd_issue && (state_next == SC_SCAN);
  assign chk_idx_next = rd_idx[IW-1:0];

  // checks
  `NTWA_ASSERT(a_count_matches_valid, clk, rst, CW'($countones(valid)) == count, "count mismatch")
  `NTWA_ASSERT_NEVER(a_count_range, clk, rst, count > CW'(TABLE_DEPTH), "count overflow")
  `NTWA_ASSERT(a_write_in_scan, clk, rst, ram_we |-> (state == SC_SCAN && chk_vld), "stray write")
  `NTWA_ASSERT(a_not_last_is_removal, clk, rst, (done && !result.last) |-> (result.status == ST_REMOVED), "bad status")

endmodule

/* rtl/neighbor_table_with_aging_top.sv */
// Neighbor table top: config registers, table ram and scan sequencer.
// A self-address update gives its result in the cycle after acceptance; any other update walks
// the table, ending at the matching slot, or after the last slot when the entry is new or full.
// Prune: one result per removed entry as the walk passes it, then a summary after the last slot.
// Items are taken only while idle, so a new item waits for the single ram read port walk to end.
// Reset clears valid bits and count at once and loads register defaults; no clearing pass.
`timescale 1ns / 1ps

module neighbor_table_with_aging_top
  import ntwa_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  in_item_t         item,
  output logic             done,
  output result_t          result,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [MAC_W-1:0] cfg_data
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  cfg_t               cfg;
  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_address <= '0;
      cfg.age_limit   <= AGE_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_OWN_ADDRESS: cfg.own_address <= cfg_data;
        CFG_AGE_LIMIT:   cfg.age_limit   <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // address and last-seen time per slot
  ntwa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // table walk and result generation
  ntwa_scan #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg       (cfg),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .done      (done),
    .result    (result)
  );

endmodule
